### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mfq_pkg.sv
package mfq_pkg;

	localparam int LEVELS      = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 8;

	localparam int LVL_W     = $clog2(LEVELS);
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int TICK_W    = LEVELS + 4;
	localparam int ADDR_W    = LVL_W + PTR_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DISP = 2'd1,
		CMD_TICK = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2,
		ST_IGN  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic respond;
		logic busy;
	} ctrl_cmd_t;

	function automatic logic [TICK_W-1:0] quantum(input logic [LVL_W-1:0] lvl);
		logic [TICK_W-1:0] q;
		q = TICK_W'(4) << lvl;
		if (lvl == LVL_W'(LEVELS - 1))
			q = q << 2;
		return q;
	endfunction

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

### src/mfq_ctrl.sv
module mfq_ctrl import mfq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output ctrl_cmd_t ctrl
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= CS_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					ctrl.latch = 1'b1;
					state_d    = CS_EXEC;
				end
			end
			CS_EXEC: begin
				ctrl.exec = 1'b1;
				ctrl.busy = 1'b1;
				state_d   = CS_RESP;
			end
			CS_RESP: begin
				ctrl.respond = 1'b1;
				if (start) begin
					ctrl.latch = 1'b1;
					state_d    = CS_EXEC;
				end else begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

endmodule

### src/mfq_datapath.sv
module mfq_datapath import mfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  ctrl,
	input  logic [1:0] cmd,
	input  logic [7:0] thread_id,
	input  logic [7:0] priority_req,
	input  logic       idle_mode,
	output logic [1:0] status,
	output logic [7:0] chosen_thread,
	output logic [1:0] chosen_level,
	output logic       yield_now
);

	logic [ID_WIDTH-1:0] mem [MEM_DEPTH];
	logic [ID_WIDTH-1:0] rd_data_q;

	logic [1:0]          cmd_q;
	logic [ID_WIDTH-1:0] tid_q;
	logic [LVL_W-1:0]    lvl_q;
	logic                idle_q;

	logic [PTR_W-1:0]    head_q  [LEVELS];
	logic [PTR_W-1:0]    tail_q  [LEVELS];
	logic [CNT_W-1:0]    count_q [LEVELS];

	logic [ID_WIDTH-1:0] run_thread_q;
	logic                run_valid_q;
	logic [LVL_W-1:0]    run_level_q;
	logic [TICK_W-1:0]   ticks_q;
	logic                reload_q;

	status_t             res_status_q;
	logic [ID_WIDTH-1:0] res_thread_q;
	logic [LVL_W-1:0]    res_level_q;
	logic                res_yield_q;
	logic                res_disp_q;

	logic [LVL_W-1:0]    lvl_in;
	logic [LVL_W-1:0]    sel_lvl;
	logic                hit;
	logic                full;
	logic [TICK_W-1:0]   tl;
	logic                expired;
	logic [LVL_W-1:0]    bumped_lvl;
	logic [ADDR_W-1:0]   waddr;
	logic [ADDR_W-1:0]   raddr;

	assign lvl_in = (priority_req > 8'(LEVELS - 1)) ? LVL_W'(LEVELS - 1)
		: LVL_W'(priority_req);

	always_comb begin
		hit     = 1'b0;
		sel_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				hit     = 1'b1;
				sel_lvl = LVL_W'(i);
			end
		end
	end

	assign full       = (count_q[lvl_q] == CNT_W'(QUEUE_DEPTH));
	assign waddr      = {lvl_q, tail_q[lvl_q]};
	assign raddr      = {sel_lvl, head_q[sel_lvl]};
	assign tl         = reload_q ? quantum(run_level_q) : ticks_q;
	assign expired    = (tl == '0);
	assign bumped_lvl = (run_level_q == LVL_W'(LEVELS - 1)) ? run_level_q
		: run_level_q + LVL_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			if (cmd_t'(cmd_q) == CMD_ENQ && !full)
				mem[waddr] <= tid_q;
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q  <= cmd;
			tid_q  <= ID_WIDTH'(thread_id);
			lvl_q  <= lvl_in;
			idle_q <= idle_mode;
		end
		if (ctrl.exec) begin
			res_status_q <= ST_IGN;
			res_thread_q <= '0;
			res_level_q  <= '0;
			res_yield_q  <= 1'b0;
			res_disp_q   <= 1'b0;
			case (cmd_t'(cmd_q))
				CMD_ENQ: begin
					res_status_q <= full ? ST_FULL : ST_OK;
					res_thread_q <= tid_q;
					res_level_q  <= lvl_q;
				end
				CMD_DISP: begin
					if (hit) begin
						res_status_q <= ST_OK;
						res_level_q  <= sel_lvl;
						res_disp_q   <= 1'b1;
					end else begin
						res_status_q <= ST_NONE;
					end
				end
				CMD_TICK: begin
					if (idle_q) begin
						res_status_q <= ST_IGN;
					end else if (!run_valid_q) begin
						res_status_q <= ST_NONE;
					end else begin
						res_status_q <= ST_OK;
						res_thread_q <= run_thread_q;
						res_level_q  <= expired ? bumped_lvl : run_level_q;
						res_yield_q  <= expired;
					end
				end
				default: res_status_q <= ST_IGN;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
			run_thread_q <= '0;
			run_valid_q  <= 1'b0;
			run_level_q  <= '0;
			ticks_q      <= '0;
			reload_q     <= 1'b1;
		end else begin
			if (ctrl.respond && res_disp_q)
				run_thread_q <= rd_data_q;
			if (ctrl.exec) begin
				case (cmd_t'(cmd_q))
					CMD_ENQ: begin
						if (!full) begin
							tail_q[lvl_q]  <= wrap_next(tail_q[lvl_q]);
							count_q[lvl_q] <= count_q[lvl_q] + CNT_W'(1);
						end
					end
					CMD_DISP: begin
						if (hit) begin
							head_q[sel_lvl]  <= wrap_next(head_q[sel_lvl]);
							count_q[sel_lvl] <= count_q[sel_lvl] - CNT_W'(1);
							run_level_q      <= sel_lvl;
							run_valid_q      <= 1'b1;
							reload_q         <= 1'b1;
						end
					end
					CMD_TICK: begin
						if (!idle_q && run_valid_q) begin
							reload_q <= 1'b0;
							if (expired) begin
								ticks_q     <= tl;
								run_level_q <= bumped_lvl;
							end else begin
								ticks_q <= tl - TICK_W'(1);
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign status        = res_status_q;
	assign chosen_thread = 8'(res_disp_q ? rd_data_q : res_thread_q);
	assign chosen_level  = 2'(res_level_q);
	assign yield_now     = res_yield_q;

endmodule

### src/multilevel_feedback_queue_scheduler.sv
// Multilevel feedback queue scheduler.
// Command channel: an item (cmd, thread_id, priority_req, idle_mode) is taken
// at a rising edge with start high and busy low. cmd selects enqueue of a ready
// thread, dispatch of the next thread, or a timer tick; code 3 is ignored.
// Result channel: done is high for one cycle with status, chosen_thread,
// chosen_level and yield_now valid; the receiver must take it then, it cannot
// stall the block.
// The accepting edge starts the single busy cycle, in which the state update and
// the registered queue memory read happen together; done is high in the cycle
// after it. busy is high in the cycle where the queue memory is accessed, and a
// new item may be taken while a result is being shown.
// Reset: arst_n clears all queues to empty, no thread running, quantum reload
// armed. Queue storage is not cleared and needs no clearing pass; the block
// accepts items from the first cycle after reset.
`include "assert_macros.svh"

module multilevel_feedback_queue_scheduler import mfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [7:0] thread_id,
	input  logic [7:0] priority_req,
	input  logic       idle_mode,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] chosen_thread,
	output logic [1:0] chosen_level,
	output logic       yield_now
);

	ctrl_cmd_t ctrl;

	mfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ctrl   (ctrl)
	);

	mfq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cmd           (cmd),
		.thread_id     (thread_id),
		.priority_req  (priority_req),
		.idle_mode     (idle_mode),
		.status        (status),
		.chosen_thread (chosen_thread),
		.chosen_level  (chosen_level),
		.yield_now     (yield_now)
	);

	assign busy = ctrl.busy;
	assign done = ctrl.respond;

	`ASSERT_NXT(a_accept_busy, start && !busy, busy && !done, "accepted item did not start")
	`ASSERT_NXT(a_busy_done, busy, done && !busy, "item produced no result")
	`ASSERT_IMP(a_done_not_busy, done, !busy, "result shown while busy")
	`ASSERT_IMP(a_yield_ok, done && yield_now, status == ST_OK, "yield with bad status")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mfq_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		status_t          st;
		logic [7:0]       thr;
		logic [LVL_W-1:0] lvl;
		logic             yld;
	} sched_result_t;

	class sched_checker;
		logic [7:0]  slots [LEVELS][QUEUE_DEPTH];
		int unsigned head [LEVELS];
		int unsigned tail [LEVELS];
		int unsigned used [LEVELS];
		logic [7:0]  run_thread;
		logic        run_valid;
		int unsigned run_level;
		int unsigned ticks_left;
		logic        reload_armed;
		sched_result_t awaited [$];
		int mismatches;

		function new();
			for (int l = 0; l < LEVELS; l++) begin
				head[l] = 0;
				tail[l] = 0;
				used[l] = 0;
			end
			run_thread   = '0;
			run_valid    = 1'b0;
			run_level    = 0;
			ticks_left   = 0;
			reload_armed = 1'b1;
			mismatches   = 0;
		endfunction

		function int unsigned quantum_of(int unsigned lvl);
			int unsigned q;
			q = 4 << lvl;
			if (lvl == LEVELS - 1)
				q = q << 2;
			return q;
		endfunction

		function int unsigned queued_total();
			int unsigned s;
			s = 0;
			for (int l = 0; l < LEVELS; l++)
				s += used[l];
			return s;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_command(logic [1:0] c, logic [7:0] tid, logic [7:0] preq,
				logic idl);
			sched_result_t r;
			int unsigned lv;
			bit found;
			r.st  = ST_IGN;
			r.thr = '0;
			r.lvl = '0;
			r.yld = 1'b0;
			found = 0;
			case (c)
				CMD_ENQ: begin
					lv = (preq > LEVELS - 1) ? LEVELS - 1 : preq;
					r.thr = tid;
					r.lvl = LVL_W'(lv);
					if (used[lv] >= QUEUE_DEPTH) begin
						r.st = ST_FULL;
					end else begin
						slots[lv][tail[lv]] = tid;
						tail[lv] = (tail[lv] + 1) % QUEUE_DEPTH;
						used[lv]++;
						r.st = ST_OK;
					end
				end
				CMD_DISP: begin
					r.st = ST_NONE;
					for (int l = 0; l < LEVELS; l++) begin
						if (!found && used[l] != 0) begin
							found = 1;
							run_thread = slots[l][head[l]];
							head[l] = (head[l] + 1) % QUEUE_DEPTH;
							used[l]--;
							run_level    = l;
							run_valid    = 1'b1;
							reload_armed = 1'b1;
							r.st  = ST_OK;
							r.thr = run_thread;
							r.lvl = LVL_W'(l);
						end
					end
				end
				CMD_TICK: begin
					if (idl) begin
						r.st = ST_IGN;
					end else if (!run_valid) begin
						r.st = ST_NONE;
					end else begin
						if (reload_armed) begin
							ticks_left   = quantum_of(run_level);
							reload_armed = 1'b0;
						end
						if (ticks_left == 0) begin
							r.yld = 1'b1;
							if (run_level < LEVELS - 1)
								run_level++;
						end else begin
							ticks_left--;
						end
						r.st  = ST_OK;
						r.thr = run_thread;
						r.lvl = LVL_W'(run_level);
					end
				end
				default: r.st = ST_IGN;
			endcase
			awaited.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic [1:0] st, logic [7:0] thr, logic [1:0] lvl, logic yld);
			sched_result_t e;
			if (awaited.size() == 0) begin
				report_mismatch("result with no item outstanding");
				return;
			end
			e = awaited.pop_front();
			if (st !== e.st)
				report_mismatch($sformatf("status %0d, want %0d", st, e.st));
			if (thr !== e.thr)
				report_mismatch($sformatf("chosen_thread %0d, want %0d", thr, e.thr));
			if (lvl !== e.lvl)
				report_mismatch($sformatf("chosen_level %0d, want %0d", lvl, e.lvl));
			if (yld !== e.yld)
				report_mismatch($sformatf("yield_now %0b, want %0b", yld, e.yld));
		endtask

		task check_leftover();
			if (awaited.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", awaited.size()));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] cmd = '0;
	logic [7:0] thread_id = '0;
	logic [7:0] priority_req = '0;
	logic       idle_mode = 1'b0;
	logic       busy;
	logic       done;
	logic [1:0] status;
	logic [7:0] chosen_thread;
	logic [1:0] chosen_level;
	logic       yield_now;

	sched_checker book;
	int sent = 0;

	multilevel_feedback_queue_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.thread_id(thread_id),
		.priority_req(priority_req),
		.idle_mode(idle_mode),
		.done(done),
		.status(status),
		.chosen_thread(chosen_thread),
		.chosen_level(chosen_level),
		.yield_now(yield_now)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			book.check_result(status, chosen_thread, chosen_level, yield_now);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [1:0] c, input logic [7:0] t, input logic [7:0] p,
			input logic i);
		if (!(sent >= 150 && sent < 260) && $urandom_range(0, 99) < 17) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start        = 1'b1;
		cmd          = c;
		thread_id    = t;
		priority_req = p;
		idle_mode    = i;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		book.note_command(c, t, p, i);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (book.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int n;
		int unsigned q;
		logic [7:0] lvl_req;
		bit deep_done;
		deep_done = 0;
		book = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(CMD_DISP, 8'd0, 8'd0, 1'b0);
		send_item(CMD_TICK, 8'd0, 8'd0, 1'b0);
		send_item(CMD_TICK, 8'd0, 8'd0, 1'b1);
		send_item(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1);
		send_item(CMD_ENQ, 8'h00, 8'd0, 1'b0);
		send_item(CMD_ENQ, 8'hFF, 8'd1, 1'b1);
		send_item(CMD_ENQ, 8'hA5, 8'd2, 1'b0);
		send_item(CMD_ENQ, 8'h5A, 8'd3, 1'b0);
		send_item(CMD_ENQ, 8'h3C, 8'hFF, 1'b0);
		send_item(CMD_ENQ, 8'hC3, 8'd4, 1'b0);
		send_item(CMD_DISP, 8'd0, 8'd0, 1'b0);
		// level 0 quantum runs out on the fifth tick, then expires again
		repeat (6) send_item(CMD_TICK, 8'd0, 8'd0, 1'b0);
		send_item(CMD_TICK, 8'd0, 8'd0, 1'b1);
		repeat (6) send_item(CMD_DISP, 8'd0, 8'd0, 1'b0);
		send_item(CMD_TICK, 8'd0, 8'd0, 1'b0);

		while (sent < 450) begin
			if (!deep_done && sent >= 300) begin
				// long quantum at the lowest-priority level (level 3), after a full drain
				deep_done = 1;
				wait_drained();
				while (book.queued_total() != 0)
					send_item(CMD_DISP, 8'($urandom), 8'($urandom), 1'($urandom));
				send_item(CMD_ENQ, 8'($urandom), 8'hFF, 1'($urandom));
				send_item(CMD_DISP, 8'($urandom), 8'($urandom), 1'($urandom));
				repeat (book.quantum_of(LEVELS - 1) + 3)
					send_item(CMD_TICK, 8'($urandom), 8'($urandom), 1'b0);
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					lvl_req = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, LEVELS - 1))
						: 8'($urandom);
					repeat ($urandom_range(1, 20))
						send_item(CMD_ENQ, 8'($urandom), lvl_req, 1'($urandom));
				end
				3, 4, 5: begin
					send_item(CMD_DISP, 8'($urandom), 8'($urandom), 1'($urandom));
					q = book.quantum_of(book.run_level);
					if (q > 40)
						n = $urandom_range(1, 12);
					else if ($urandom_range(0, 1))
						n = $urandom_range(q - 1, q + 3);
					else
						n = $urandom_range(0, q + 3);
					repeat (n)
						send_item(CMD_TICK, 8'($urandom), 8'($urandom),
							1'($urandom_range(0, 7) == 0));
				end
				6: repeat ($urandom_range(1, 8))
					send_item(CMD_DISP, 8'($urandom), 8'($urandom), 1'($urandom));
				7: repeat ($urandom_range(1, 5))
					send_item(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
				8: repeat ($urandom_range(1, 10))
					send_item(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
				default: begin
					wait_drained();
					send_item(CMD_DISP, 8'($urandom), 8'($urandom), 1'($urandom));
				end
			endcase
		end

		wait_drained();
		repeat (8) @(negedge clk);
		book.check_leftover();
		if (book.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/mfq_pkg.sv
src/mfq_ctrl.sv
src/mfq_datapath.sv
src/multilevel_feedback_queue_scheduler.sv
bench/tb_top.sv
